[sv/vpt_pkg.sv]
// ----------------------------------------------------------------------------
// vpt_pkg
// shared types and constants of the vibration pulse timer
// ----------------------------------------------------------------------------
package vpt_pkg;

    localparam int MS_W    = 16;
    localparam int CNT_W   = 20;
    localparam int CMD_W   = 3;
    localparam int CFG_A_W = 8;
    localparam int CFG_D_W = 20;

    // command codes carried on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_ONESHOT = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_TIMEOUT  = 8'd0;
    localparam logic [CFG_A_W-1:0] REG_ON_TIME  = 8'd1;
    localparam logic [CFG_A_W-1:0] REG_OFF_TIME = 8'd2;
    localparam logic [CFG_A_W-1:0] REG_TARGET   = 8'd3;

    // register reset values
    localparam logic [MS_W-1:0]  TIMEOUT_RST  = 16'd15000;
    localparam logic [MS_W-1:0]  ON_TIME_RST  = 16'd2000;
    localparam logic [MS_W-1:0]  OFF_TIME_RST = 16'd1000;
    localparam logic [CNT_W-1:0] TARGET_RST   = 20'd120000;

endpackage

[sv/vibration_pulse_timer_top.sv]
// ----------------------------------------------------------------------------
// vibration_pulse_timer_top
// millisecond-tick motor drive timer with one-shot and endurance modes
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   a 1 ms tick, a one-shot of i_duration_ms, endurance start, endurance stop
//   or clear count. every transfer produces exactly one result on the output
//   channel (o_out_valid / i_out_ready) showing the state after that command.
//   configuration port (i_cfg_valid / o_cfg_ready) writes timeout, on time,
//   off time and cycle target; always ready; user must write only while idle (unchecked).
// throughput:
//   one item per cycle is sustained while i_out_ready stays high; the state
//   registers and the output register are both loaded on the accepting edge.
// stall:
//   o_in_ready is high while the output register is empty or being taken,
//   so a stalled receiver holds the result and stops new input transfers.
// reset:
//   synchronous, active low; clears all timer state and the output valid,
//   and loads the register defaults (15000, 2000, 1000, 120000).
// ----------------------------------------------------------------------------
module vibration_pulse_timer_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [vpt_pkg::CMD_W-1:0]    i_command,
    input  logic [vpt_pkg::MS_W-1:0]     i_duration_ms,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_motor_on,
    output logic [vpt_pkg::MS_W-1:0]     o_remaining_ms,
    output logic                         o_endurance_running,
    output logic [vpt_pkg::CNT_W-1:0]    o_completed_cycles,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [vpt_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [vpt_pkg::CFG_D_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [vpt_pkg::MS_W-1:0]  r_timeout_ms;
    logic [vpt_pkg::MS_W-1:0]  r_on_time_ms;
    logic [vpt_pkg::MS_W-1:0]  r_off_time_ms;
    logic [vpt_pkg::CNT_W-1:0] r_cycle_target;

    // timer state
    logic [vpt_pkg::MS_W-1:0]  r_oneshot_left,  n_oneshot_left;
    logic                      r_oneshot_active, n_oneshot_active;
    logic                      r_run_active,    n_run_active;
    logic                      r_phase_is_on,   n_phase_is_on;
    logic [vpt_pkg::MS_W-1:0]  r_phase_left,    n_phase_left;
    logic [vpt_pkg::CNT_W-1:0] r_cycle_index,   n_cycle_index;
    logic [vpt_pkg::CNT_W-1:0] r_done_count,    n_done_count;

    // result register
    logic                      r_out_valid;
    logic                      r_motor_on;
    logic [vpt_pkg::MS_W-1:0]  r_remaining_ms;
    logic                      r_endurance_running;
    logic [vpt_pkg::CNT_W-1:0] r_completed_cycles;

    logic                      w_in_xfer;
    logic                      w_cfg_xfer;
    logic [vpt_pkg::MS_W-1:0]  w_dur_clamped;
    // first cycle number of a new run, one bit wider so a full count cannot wrap
    logic [vpt_pkg::CNT_W:0]   w_first;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;

    assign w_dur_clamped = (i_duration_ms > r_timeout_ms) ? r_timeout_ms : i_duration_ms;
    assign w_first       = {1'b0, r_done_count} + {{vpt_pkg::CNT_W{1'b0}}, 1'b1};

    // next state for the command being transferred
    always_comb begin
        n_oneshot_left   = r_oneshot_left;
        n_oneshot_active = r_oneshot_active;
        n_run_active     = r_run_active;
        n_phase_is_on    = r_phase_is_on;
        n_phase_left     = r_phase_left;
        n_cycle_index    = r_cycle_index;
        n_done_count     = r_done_count;

        case (vpt_pkg::t_cmd'(i_command))
            vpt_pkg::CMD_TICK: begin
                // one-shot countdown
                if (r_oneshot_active) begin
                    if (r_oneshot_left <= 16'd1) begin
                        n_oneshot_left   = '0;
                        n_oneshot_active = 1'b0;
                    end else begin
                        n_oneshot_left = r_oneshot_left - 16'd1;
                    end
                end
                // endurance phase countdown; a zero-length phase ends like a phase of one
                if (r_run_active) begin
                    if (r_phase_left > 16'd1) begin
                        n_phase_left = r_phase_left - 16'd1;
                    end else if (r_phase_is_on) begin
                        n_phase_is_on = 1'b0;
                        n_phase_left  = r_off_time_ms;
                    end else begin
                        // off phase done: cycle finished
                        n_done_count = r_cycle_index;
                        if (r_cycle_index >= r_cycle_target) begin
                            n_run_active = 1'b0;
                            n_phase_left = '0;
                        end else begin
                            n_cycle_index = r_cycle_index + 20'd1;
                            n_phase_is_on = 1'b1;
                            n_phase_left  = r_on_time_ms;
                        end
                    end
                end
            end
            vpt_pkg::CMD_ONESHOT: begin
                // zero duration (or zero timeout) turns the one-shot off
                n_oneshot_left   = w_dur_clamped;
                n_oneshot_active = (w_dur_clamped != '0);
            end
            vpt_pkg::CMD_START: begin
                // ignored while running or when the target is already reached
                if (!r_run_active && (w_first <= {1'b0, r_cycle_target})) begin
                    n_cycle_index = w_first[vpt_pkg::CNT_W-1:0];
                    n_run_active  = 1'b1;
                    n_phase_is_on = 1'b1;
                    n_phase_left  = r_on_time_ms;
                end
            end
            vpt_pkg::CMD_STOP: begin
                // while running: cycle in progress counts; motor forced off, one-shot cancelled
                if (r_run_active) begin
                    n_done_count     = r_cycle_index;
                    n_run_active     = 1'b0;
                    n_phase_is_on    = 1'b0;
                    n_phase_left     = '0;
                    n_oneshot_active = 1'b0;
                    n_oneshot_left   = '0;
                end
            end
            vpt_pkg::CMD_CLEAR: begin
                n_done_count = '0;
            end
            default: begin
                // undefined codes leave the state alone but still report
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms   <= vpt_pkg::TIMEOUT_RST;
            r_on_time_ms   <= vpt_pkg::ON_TIME_RST;
            r_off_time_ms  <= vpt_pkg::OFF_TIME_RST;
            r_cycle_target <= vpt_pkg::TARGET_RST;
        end else if (w_cfg_xfer) begin
            // writes past the last register are dropped
            if (i_cfg_index == vpt_pkg::REG_TIMEOUT) begin
                r_timeout_ms <= i_cfg_data[vpt_pkg::MS_W-1:0];
            end
            if (i_cfg_index == vpt_pkg::REG_ON_TIME) begin
                r_on_time_ms <= i_cfg_data[vpt_pkg::MS_W-1:0];
            end
            if (i_cfg_index == vpt_pkg::REG_OFF_TIME) begin
                r_off_time_ms <= i_cfg_data[vpt_pkg::MS_W-1:0];
            end
            if (i_cfg_index == vpt_pkg::REG_TARGET) begin
                r_cycle_target <= i_cfg_data[vpt_pkg::CNT_W-1:0];
            end
        end
    end

    // timer state, loaded on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oneshot_left   <= '0;
            r_oneshot_active <= 1'b0;
            r_run_active     <= 1'b0;
            r_phase_is_on    <= 1'b0;
            r_phase_left     <= '0;
            r_cycle_index    <= '0;
            r_done_count     <= '0;
        end else if (w_in_xfer) begin
            r_oneshot_left   <= n_oneshot_left;
            r_oneshot_active <= n_oneshot_active;
            r_run_active     <= n_run_active;
            r_phase_is_on    <= n_phase_is_on;
            r_phase_left     <= n_phase_left;
            r_cycle_index    <= n_cycle_index;
            r_done_count     <= n_done_count;
        end
    end

    // output register: valid handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register: payload reflects the state after the command
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_motor_on          <= n_oneshot_active || (n_run_active && n_phase_is_on);
            r_remaining_ms      <= n_oneshot_active ? n_oneshot_left : '0;
            r_endurance_running <= n_run_active;
            r_completed_cycles  <= n_done_count;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_motor_on          = r_motor_on;
    assign o_remaining_ms      = r_remaining_ms;
    assign o_endurance_running = r_endurance_running;
    assign o_completed_cycles  = r_completed_cycles;

endmodule

[sv/vpt_checker.sv]
// ----------------------------------------------------------------------------
// vpt_checker
// port-level checks of the vibration pulse timer
// ----------------------------------------------------------------------------
module vpt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [vpt_pkg::CMD_W-1:0]    i_command,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_motor_on,
    input logic [vpt_pkg::MS_W-1:0]     o_remaining_ms,
    input logic [vpt_pkg::CNT_W-1:0]    o_completed_cycles
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_remaining_ms)
            && $stable(o_completed_cycles) && $stable(o_motor_on))
        else $error("stalled result changed");

    // every input transfer shows a result the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after input transfer");

    // an empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // time left on a one-shot means the motor is driven
    a_remaining_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_remaining_ms != '0) |-> o_motor_on)
        else $error("one-shot time left with motor off");

    // clearing the count reports zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == vpt_pkg::CMD_CLEAR)
            |=> o_completed_cycles == '0)
        else $error("count not zero after clear");

endmodule

bind vibration_pulse_timer_top vpt_checker u_vpt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_command          (i_command),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_motor_on         (o_motor_on),
    .o_remaining_ms     (o_remaining_ms),
    .o_completed_cycles (o_completed_cycles)
);
